// ----- rtl/core/echoing_decimal_line_reader_macros.svh -----
// Assertion helpers shared by the line reader modules.
`ifndef ECHOING_DECIMAL_LINE_READER_MACROS_SVH
`define ECHOING_DECIMAL_LINE_READER_MACROS_SVH

`ifndef SYNTHESIS
`define EDLR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EDLR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EDLR_ASSERT(lbl, clk, rst_n, prop, msg)
`define EDLR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/core/edlr_pkg.sv -----
package edlr_pkg;

	localparam logic [1:0] OP_STORE   = 2'd0;
	localparam logic [1:0] OP_SPACE   = 2'd1;
	localparam logic [1:0] OP_NEWLINE = 2'd2;
	localparam logic [1:0] OP_ERASE   = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [31:0] DIGIT_BASE = 32'd48;

	localparam logic KIND_ECHO  = 1'b0;
	localparam logic KIND_VALUE = 1'b1;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} cmd_t;

endpackage

// ----- rtl/core/echoing_decimal_line_reader.sv -----
// Console line reader with echo and decimal conversion.
// Input channel rx_valid/rx_stall/rx_byte takes one console byte per request.
// Result channel res_valid/res_stall carries result_kind, echo_char,
// line_value and last_of_run; last_of_run marks the final result of a byte.
// Ordinary bytes are stored and echoed; DEL or backspace echoes BS, SP, BS
// and drops the last stored byte; space, CR or LF echo and end the line, as
// does the byte that fills LINE_CAPACITY-1 entries. A finished line gives
// one more result with its signed decimal value (leading '-' negates).
// The first echo passes through the front register, the request queue and the
// output register. An erase holds the back end for its three echoes, and a
// line end for the conversion walk, which reads the line store one entry per
// cycle. A 4-entry request queue lets the input side keep accepting while the
// back end works.
// A stalled result is held in the output register; the back end waits and
// the input side stalls once the queue is full.
// Reset empties the queue and clears the fill count; the line store is not
// cleared and needs no clearing pass.
module echoing_decimal_line_reader
	import edlr_pkg::*;
#(
	parameter int LINE_CAPACITY = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rx_valid,
	output logic rx_stall,
	input  logic [7:0] rx_byte,
	output logic res_valid,
	input  logic res_stall,
	output logic result_kind,
	output logic [7:0] echo_char,
	output logic signed [31:0] line_value,
	output logic last_of_run
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	edlr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	edlr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	edlr_back #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.result_kind (result_kind),
		.echo_char   (echo_char),
		.line_value  (line_value),
		.last_of_run (last_of_run)
	);

endmodule

// ----- rtl/core/edlr_front.sv -----
module edlr_front
	import edlr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic rx_valid,
	output logic rx_stall,
	input  logic [7:0] rx_byte,
	input  logic q_full,
	output logic push,
	output cmd_t push_cmd
);

	logic cmd_v_q;
	cmd_t cmd_q;
	cmd_t cls;
	logic take;

	always_comb begin
		cls.data = rx_byte;
		if (rx_byte == CH_SP) begin
			cls.op = OP_SPACE;
		end else if (rx_byte == CH_LF || rx_byte == CH_CR) begin
			cls.op = OP_NEWLINE;
		end else if (rx_byte == CH_DEL || rx_byte == CH_BS) begin
			cls.op = OP_ERASE;
		end else begin
			cls.op = OP_STORE;
		end
	end

	assign rx_stall = cmd_v_q && q_full;
	assign take     = rx_valid && !rx_stall;
	assign push     = cmd_v_q && !q_full;
	assign push_cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_q <= 1'b0;
		end else begin
			cmd_v_q <= take || rx_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cls;
		end
	end

endmodule

// ----- rtl/core/edlr_queue.sv -----
`include "echoing_decimal_line_reader_macros.svh"

module edlr_queue
	import edlr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd,
	input  logic pop
);

	cmd_t slot_q [0:Q_DEPTH-1];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0] used_q;

	assign full       = used_q == (Q_AW+1)'(Q_DEPTH);
	assign head_valid = used_q != '0;
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				used_q <= used_q + 1'b1;
			end else if (pop && !push) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	`EDLR_ASSERT_NEVER(a_q_no_overflow, clk, arst_n, push && full && !pop, "request queue overflow")
	`EDLR_ASSERT_NEVER(a_q_no_underflow, clk, arst_n, pop && !head_valid, "request queue underflow")

endmodule

// ----- rtl/core/edlr_back.sv -----
`include "echoing_decimal_line_reader_macros.svh"

module edlr_back
	import edlr_pkg::*;
#(
	parameter int LINE_CAPACITY = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  cmd_t head_cmd,
	output logic pop,
	output logic res_valid,
	input  logic res_stall,
	output logic result_kind,
	output logic [7:0] echo_char,
	output logic signed [31:0] line_value,
	output logic last_of_run
);

	localparam int CW = $clog2(LINE_CAPACITY);
	localparam logic [CW-1:0] FILL_LAST = CW'(LINE_CAPACITY - 2);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ER_SP = 3'd1;
	localparam logic [2:0] ST_ER_BS = 3'd2;
	localparam logic [2:0] ST_CONV  = 3'd3;
	localparam logic [2:0] ST_VAL   = 3'd4;

	logic [7:0] mem [0:LINE_CAPACITY-2];

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic [CW-1:0] count_q;
	logic res_valid_q;
	logic rd_v_q;

	logic [CW-1:0] rd_idx_q;
	logic [7:0] rd_data_q;
	logic rd_first_q;
	logic [31:0] acc_q;
	logic neg_q;

	logic res_kind_q;
	logic [7:0] res_char_q;
	logic [31:0] res_value_q;
	logic res_last_q;

	logic out_free;
	logic emit;
	logic e_kind;
	logic [7:0] e_char;
	logic [31:0] e_value;
	logic e_last;
	logic conv_start;
	logic issue;
	logic is_minus;
	logic stop;
	logic conv_done;
	logic [31:0] acc_next;

	assign out_free = !res_valid_q || !res_stall;
	assign pop      = (state_q == ST_IDLE) && head_valid && out_free;

	assign issue     = (state_q == ST_CONV) && (rd_idx_q < count_q);
	assign is_minus  = rd_first_q && (rd_data_q == CH_MINUS);
	assign stop      = rd_v_q && !is_minus && (rd_data_q == CH_NUL);
	assign conv_done = (state_q == ST_CONV) && (stop || (!rd_v_q && !(rd_idx_q < count_q)));
	assign acc_next  = (acc_q << 3) + (acc_q << 1) + ({24'd0, rd_data_q} - DIGIT_BASE);

	always_comb begin
		state_nx   = state_q;
		emit       = 1'b0;
		e_kind     = KIND_ECHO;
		e_char     = CH_NUL;
		e_value    = '0;
		e_last     = 1'b0;
		conv_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					emit = 1'b1;
					case (head_cmd.op)
						OP_SPACE: begin
							e_char     = CH_SP;
							conv_start = 1'b1;
						end
						OP_NEWLINE: begin
							e_char     = CH_LF;
							conv_start = 1'b1;
						end
						OP_ERASE: begin
							e_char   = CH_BS;
							state_nx = ST_ER_SP;
						end
						default: begin
							e_char     = head_cmd.data;
							conv_start = count_q == FILL_LAST;
							e_last     = !conv_start;
						end
					endcase
					if (conv_start) begin
						state_nx = ST_CONV;
					end
				end
			end
			ST_ER_SP: begin
				if (out_free) begin
					emit     = 1'b1;
					e_char   = CH_SP;
					state_nx = ST_ER_BS;
				end
			end
			ST_ER_BS: begin
				if (out_free) begin
					emit     = 1'b1;
					e_char   = CH_BS;
					e_last   = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_nx = ST_VAL;
				end
			end
			ST_VAL: begin
				if (out_free) begin
					emit     = 1'b1;
					e_kind   = KIND_VALUE;
					e_value  = neg_q ? (32'd0 - acc_q) : acc_q;
					e_last   = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			rd_v_q      <= 1'b0;
		end else begin
			state_q <= state_nx;
			rd_v_q  <= issue;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (pop && head_cmd.op == OP_STORE) begin
				count_q <= count_q + 1'b1;
			end else if (pop && head_cmd.op == OP_ERASE && count_q != '0) begin
				count_q <= count_q - 1'b1;
			end else if (state_q == ST_VAL && out_free) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_cmd.op == OP_STORE) begin
			mem[count_q] <= head_cmd.data;
		end
		if (conv_start) begin
			rd_idx_q <= '0;
			acc_q    <= '0;
			neg_q    <= 1'b0;
		end else begin
			// walk the line: read one byte ahead, fold the previous one in
			if (issue) begin
				rd_data_q  <= mem[rd_idx_q];
				rd_first_q <= rd_idx_q == '0;
				rd_idx_q   <= rd_idx_q + 1'b1;
			end
			if (state_q == ST_CONV && rd_v_q && !stop) begin
				if (is_minus) begin
					neg_q <= 1'b1;
				end else begin
					acc_q <= acc_next;
				end
			end
		end
		if (emit) begin
			res_kind_q  <= e_kind;
			res_char_q  <= e_char;
			res_value_q <= e_value;
			res_last_q  <= e_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign result_kind = res_kind_q;
	assign echo_char   = res_char_q;
	assign line_value  = res_value_q;
	assign last_of_run = res_last_q;

	// a full line holds one entry more only while it is being converted
	`EDLR_ASSERT_NEVER(a_fill_below_cap, clk, arst_n, state_q == ST_IDLE && count_q > FILL_LAST,
		"fill count reached capacity")
	`EDLR_ASSERT(a_value_is_last, clk, arst_n, (res_valid_q && res_kind_q == KIND_VALUE) |-> res_last_q, "line value not marked last")
	`EDLR_ASSERT(a_clear_after_value, clk, arst_n, (state_q == ST_VAL && out_free) |=> (count_q == '0), "fill count not cleared after line value")

endmodule

// ----- bench/tb_echoing_decimal_line_reader.sv -----
`timescale 1ns / 100ps

module tb_echoing_decimal_line_reader;
	import edlr_pkg::*;

	localparam int LINE_CAP = 128;
	localparam int RANDOM_ITEMS = 280;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = LINE_CAP + 40;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic        kind;
		logic [7:0]  ch;
		logic [31:0] value;
		logic        last;
	} line_result_t;

	// pin: the line value of a terminator row is typed in below
	typedef struct packed {
		logic [7:0]  b;
		logic        pin;
		logic [31:0] value;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic rx_stall;
	logic [7:0] rx_byte = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic result_kind;
	logic [7:0] echo_char;
	logic signed [31:0] line_value;
	logic last_of_run;

	// travel with the request so the monitor sees them at acceptance
	logic row_pin = 1'b0;
	logic [31:0] row_pin_value = '0;

	line_result_t pending_results[$];
	logic [7:0] line_buf [0:LINE_CAP-2];
	int unsigned line_fill = 0;
	int unsigned error_count = 0;
	int unsigned bytes_sent = 0;
	bit steady = 1'b0;
	bit hold_req = 1'b0;

	stim_row_t directed_rows [0:23] = '{
		'{CH_CR,    1'b1, 32'd0},
		'{CH_BS,    1'b0, 32'd0},
		'{CH_MINUS, 1'b0, 32'd0},
		'{CH_SP,    1'b1, 32'd0},
		'{"1",      1'b0, 32'd0},
		'{"2",      1'b0, 32'd0},
		'{"3",      1'b0, 32'd0},
		'{CH_DEL,   1'b0, 32'd0},
		'{CH_LF,    1'b1, 32'd12},
		'{CH_MINUS, 1'b0, 32'd0},
		'{"4",      1'b0, 32'd0},
		'{"2",      1'b0, 32'd0},
		'{CH_CR,    1'b1, -32'sd42},
		'{8'hFF,    1'b0, 32'd0},
		'{CH_NUL,   1'b0, 32'd0},
		'{"7",      1'b0, 32'd0},
		'{CH_SP,    1'b1, 32'd207},
		'{8'h80,    1'b0, 32'd0},
		'{"5",      1'b0, 32'd0},
		'{CH_BS,    1'b0, 32'd0},
		'{CH_CR,    1'b0, 32'd0},
		'{CH_MINUS, 1'b0, 32'd0},
		'{CH_MINUS, 1'b0, 32'd0},
		'{CH_LF,    1'b0, 32'd0}
	};

	echoing_decimal_line_reader #(
		.LINE_CAPACITY(LINE_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.result_kind(result_kind),
		.echo_char(echo_char),
		.line_value(line_value),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] line_to_value();
		logic [31:0] acc;
		int unsigned idx;
		bit negative;
		acc = '0;
		idx = 0;
		negative = 1'b0;
		if (line_fill > 0 && line_buf[0] == CH_MINUS) begin
			negative = 1'b1;
			idx = 1;
		end
		while (idx < line_fill) begin
			// a stored NUL ends the walk
			if (line_buf[idx] == CH_NUL)
				break;
			acc = acc * 32'd10 + {24'd0, line_buf[idx]} - DIGIT_BASE;
			idx++;
		end
		return negative ? -acc : acc;
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic pin,
			input logic [31:0] pin_value);
		line_result_t r [0:2];
		int n;
		bit line_done;
		n = 0;
		line_done = 1'b0;
		if (b == CH_SP) begin
			r[n++] = '{KIND_ECHO, CH_SP, 32'd0, 1'b0};
			line_done = 1'b1;
		end else if (b == CH_LF || b == CH_CR) begin
			r[n++] = '{KIND_ECHO, CH_LF, 32'd0, 1'b0};
			line_done = 1'b1;
		end else if (b == CH_DEL || b == CH_BS) begin
			r[n++] = '{KIND_ECHO, CH_BS, 32'd0, 1'b0};
			r[n++] = '{KIND_ECHO, CH_SP, 32'd0, 1'b0};
			r[n++] = '{KIND_ECHO, CH_BS, 32'd0, 1'b0};
			if (line_fill > 0)
				line_fill--;
		end else begin
			if (line_fill < LINE_CAP - 1) begin
				line_buf[line_fill] = b;
				line_fill++;
			end
			r[n++] = '{KIND_ECHO, b, 32'd0, 1'b0};
			if (line_fill >= LINE_CAP - 1)
				line_done = 1'b1;
		end
		if (line_done) begin
			r[n++] = '{KIND_VALUE, CH_NUL, pin ? pin_value : line_to_value(), 1'b0};
			line_fill = 0;
		end
		r[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.push_back(r[i]);
	endfunction

	function automatic void check_result();
		line_result_t want;
		if (pending_results.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("unexpected result: kind %0d char %02h value %0d last %0d",
					result_kind, echo_char, line_value, last_of_run);
			return;
		end
		want = pending_results.pop_front();
		if (result_kind !== want.kind || echo_char !== want.ch ||
				line_value !== want.value || last_of_run !== want.last) begin
			error_count++;
			if (error_count <= 10)
				$display("mismatch: expected kind %0d char %02h value %0d last %0d, got kind %0d char %02h value %0d last %0d",
					want.kind, want.ch, $signed(want.value), want.last,
					result_kind, echo_char, line_value, last_of_run);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall)
				predict_byte(rx_byte, row_pin, row_pin_value);
			if (res_valid && !res_stall)
				check_result();
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int unsigned hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= !steady && ($urandom_range(99) < 18);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_echoing_decimal_line_reader: errors");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic pin = 1'b0,
			input logic [31:0] pin_value = '0);
		while (!steady && $urandom_range(99) < 18) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		row_pin <= pin;
		row_pin_value <= pin_value;
		@(posedge clk);
		// hold the request until it is taken
		while (rx_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] digit_byte();
		return 8'(DIGIT_BASE + $urandom_range(9));
	endfunction

	function automatic logic [7:0] erase_byte();
		return $urandom_range(1) ? CH_BS : CH_DEL;
	endfunction

	function automatic logic [7:0] ordinary_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_SP || b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL);
		return b;
	endfunction

	task automatic send_number_line();
		int unsigned digits;
		logic [7:0] term;
		if ($urandom_range(99) < 30)
			send_byte(CH_MINUS);
		digits = $urandom_range(10);
		repeat (digits) begin
			send_byte(digit_byte());
			if ($urandom_range(9) == 0)
				send_byte(erase_byte());
		end
		case ($urandom_range(2))
			0: term = CH_SP;
			1: term = CH_CR;
			default: term = CH_LF;
		endcase
		send_byte(term);
	endtask

	// fill the store to capacity so the line ends on its own
	task automatic send_full_line();
		int unsigned stored;
		stored = 0;
		while (stored < LINE_CAP - 1) begin
			if (stored > 0 && $urandom_range(19) == 0) begin
				send_byte(erase_byte());
				stored--;
			end else begin
				if (stored == 0 && $urandom_range(1))
					send_byte(CH_MINUS);
				else
					send_byte($urandom_range(7) == 0 ? ordinary_byte() : digit_byte());
				stored++;
			end
		end
	endtask

	initial begin
		int unsigned target;
		bit long_done;
		bit paused;
		long_done = 1'b0;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].pin, directed_rows[i].value);
		wait_drained();

		target = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < target) begin
			steady = (bytes_sent + 260 >= target && bytes_sent + 210 < target);
			if (!hold_req && bytes_sent + 120 >= target)
				hold_req = 1'b1;
			if (!paused && bytes_sent + 40 >= target) begin
				wait_drained();
				paused = 1'b1;
			end
			if (!long_done && bytes_sent + 200 >= target) begin
				send_full_line();
				long_done = 1'b1;
			end else if ($urandom_range(9) < 7) begin
				send_number_line();
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(255)));
			end
		end
		steady = 1'b0;

		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("tb_echoing_decimal_line_reader: clean");
		else
			$display("tb_echoing_decimal_line_reader: errors");
		$finish;
	end

endmodule
